/* rtl/command_packet_framer_defines.svh */
// Assertion macros for the framer RTL.
`ifndef COMMAND_PACKET_FRAMER_DEFINES_SVH
`define COMMAND_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("command_packet_framer: check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("command_packet_framer: check failed");

`endif

/* rtl/cpf_pkg.sv */
`default_nettype none

package cpf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned FrameMax  = 12;
  localparam int unsigned CntW      = $clog2(FrameMax + 1);

  localparam logic [ByteW-1:0] HdrHi       = 8'hEF;
  localparam logic [ByteW-1:0] HdrLo       = 8'h01;
  localparam logic [LenW-1:0]  LenOverhead = 16'd2;
  localparam logic [AddrW-1:0] AddrReset   = 32'hFFFF_FFFF;

  localparam logic [CntW-1:0] CntFirstOpen  = CntW'(10);
  localparam logic [CntW-1:0] CntFirstClose = CntW'(12);
  localparam logic [CntW-1:0] CntMidOpen    = CntW'(1);
  localparam logic [CntW-1:0] CntMidClose   = CntW'(3);

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  content_length;
    logic [ByteW-1:0] packet_id;
  } item_t;

  typedef struct packed {
    logic [FrameMax-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                count;
    logic                           closes;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/command_packet_framer.sv */
// Channel        Direction  Width  Contents
// s_axis         in         32     packet_id, content_length, data_byte
// m_axis         out        8      tx_byte, with tlast as end_of_packet
// cfg            in         32     device_address, write only
//
// An input transfer yields 1, 3, 10 or 12 output bytes, one byte per cycle
// while m_axis_tready is high; 10 or 12 for a packet's first byte, 1 or 3 later.
// A one-item input register lets the next item in while bytes still drain.
// A frame loads when the output shift register is empty or its last byte leaves.
// Reset restores the address to all ones and waits for a packet's first byte.
`default_nettype none

`include "command_packet_framer_defines.svh"

module command_packet_framer import cpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] packet_id, [23:8] content_length, [31:24] data_byte
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] tx_byte
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  item_t           item;
  logic            item_valid;
  logic            frame_ready;
  logic            load;
  frame_t          frame;
  logic [CntW-1:0] emit_cnt;

  assign load = item_valid && frame_ready;

  cpf_input_stage u_input_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (item_t'(s_axis_tdata_i)),
    .load_i       (load),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cpf_frame_builder u_frame_builder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .load_i      (load),
    .item_i      (item),
    .frame_o     (frame)
  );

  cpf_byte_emitter u_byte_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .count_o       (emit_cnt),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

  `CPF_ASSERT_IMPL(a_cnt_bound, 1'b1, emit_cnt <= CntW'(FrameMax))
  `CPF_ASSERT_IMPL(a_last_on_final, m_axis_tvalid_o && m_axis_tlast_o, emit_cnt == CntW'(1))
  `CPF_ASSERT_IMPL(a_load_when_drained, load,
                   emit_cnt == '0 || (emit_cnt == CntW'(1) && m_axis_tready_i))
  `CPF_ASSERT_NEXT(a_idle_after_last,
                   m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o && !load,
                   !m_axis_tvalid_o)

endmodule

`default_nettype wire

/* rtl/cpf_input_stage.sv */
`default_nettype none

module cpf_input_stage import cpf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  input  wire logic  load_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o   = !valid_q || load_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (load_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/cpf_frame_builder.sv */
`default_nettype none

module cpf_frame_builder import cpf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_wdata_i,
  input  wire logic             load_i,
  input  wire item_t            item_i,
  output frame_t                frame_o
);

  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  sum_q, sum_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             in_pkt_q, in_pkt_d;

  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] pkt_len;
  logic [LenW-1:0] sum_base;
  logic [LenW-1:0] sum_new;
  logic [LenW-1:0] rem_base;
  logic [LenW-1:0] rem_new;
  logic            closes;

  always_comb begin
    len_eff  = (item_i.content_length == '0) ? LenW'(1) : item_i.content_length;
    pkt_len  = len_eff + LenOverhead;
    sum_base = in_pkt_q ? sum_q
             : LenW'(item_i.packet_id) + LenW'(pkt_len[LenW-1:ByteW])
               + LenW'(pkt_len[ByteW-1:0]);
    sum_new  = sum_base + LenW'(item_i.data_byte);
    rem_base = in_pkt_q ? rem_q : len_eff;
    rem_new  = rem_base - LenW'(1);
    closes   = (rem_new == '0);

    frame_o        = '0;
    frame_o.closes = closes;
    if (!in_pkt_q) begin
      frame_o.bytes[0]  = HdrHi;
      frame_o.bytes[1]  = HdrLo;
      frame_o.bytes[2]  = addr_q[31:24];
      frame_o.bytes[3]  = addr_q[23:16];
      frame_o.bytes[4]  = addr_q[15:8];
      frame_o.bytes[5]  = addr_q[7:0];
      frame_o.bytes[6]  = item_i.packet_id;
      frame_o.bytes[7]  = pkt_len[LenW-1:ByteW];
      frame_o.bytes[8]  = pkt_len[ByteW-1:0];
      frame_o.bytes[9]  = item_i.data_byte;
      frame_o.bytes[10] = sum_new[LenW-1:ByteW];
      frame_o.bytes[11] = sum_new[ByteW-1:0];
      frame_o.count     = closes ? CntFirstClose : CntFirstOpen;
    end else begin
      frame_o.bytes[0]  = item_i.data_byte;
      frame_o.bytes[1]  = sum_new[LenW-1:ByteW];
      frame_o.bytes[2]  = sum_new[ByteW-1:0];
      frame_o.count     = closes ? CntMidClose : CntMidOpen;
    end

    sum_d    = sum_q;
    rem_d    = rem_q;
    in_pkt_d = in_pkt_q;
    if (load_i) begin
      sum_d    = closes ? '0 : sum_new;
      rem_d    = rem_new;
      in_pkt_d = !closes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= AddrReset;
      sum_q    <= '0;
      rem_q    <= '0;
      in_pkt_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      sum_q    <= sum_d;
      rem_q    <= rem_d;
      in_pkt_q <= in_pkt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/cpf_byte_emitter.sv */
`default_nettype none

module cpf_byte_emitter import cpf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire frame_t           frame_i,
  output logic                  frame_ready_o,
  output logic [CntW-1:0]       count_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  out_last_o
);

  logic [FrameMax-1:0][ByteW-1:0] buf_q, buf_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           closes_q, closes_d;
  logic                           pop;

  assign out_valid_o   = (cnt_q != '0);
  assign out_byte_o    = buf_q[0];
  assign out_last_o    = closes_q && (cnt_q == CntW'(1));
  assign pop           = out_valid_o && out_ready_i;
  assign frame_ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign count_o       = cnt_q;

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    closes_d = closes_q;
    if (load_i) begin
      buf_d    = frame_i.bytes;
      cnt_d    = frame_i.count;
      closes_d = frame_i.closes;
    end else if (pop) begin
      buf_d = {ByteW'(0), buf_q[FrameMax-1:1]};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      closes_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      closes_q <= closes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire
